// ----- hw/rtl/assert_macros.svh -----
// Assertion macros used by the checker file bpc_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on clk_i, off while rst_ni is low.
`define BPC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Concurrent check on clk_i that also holds through reset.
`define BPC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ----- hw/rtl/bpc_pkg.sv -----
// Types and constants for the bitmap with population count.
package bpc_pkg;

  localparam int CAPACITY_BITS = 1024;
  localparam int WORD_BITS     = 8;
  localparam int STORE_WORDS   = (CAPACITY_BITS + WORD_BITS - 1) / WORD_BITS;

  localparam int IDX_W   = 16;
  localparam int SEL_W   = $clog2(WORD_BITS);
  localparam int ADDR_W  = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
  localparam int CNT_W   = $clog2(CAPACITY_BITS + 1);
  localparam int COUNT_W = 11;

  localparam logic [ADDR_W-1:0] LAST_WORD = ADDR_W'(STORE_WORDS - 1);
  localparam logic [IDX_W:0]    IDX_LIMIT = (IDX_W + 1)'(CAPACITY_BITS);
  localparam logic [CNT_W-1:0]  CNT_CAP   = CNT_W'(CAPACITY_BITS);

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [ADDR_W-1:0]    addr_t;

  // Operation codes; code 3 behaves as a read.
  typedef enum logic [1:0] {
    FUNC_READ  = 2'd0,
    FUNC_WRITE = 2'd1,
    FUNC_CLEAR = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RMW,
    ST_WIPE
  } state_e;

  // Write port of the bit store.
  typedef struct packed {
    logic  en;
    addr_t addr;
    word_t data;
  } wr_req_t;

endpackage

// ----- hw/rtl/bpc_store.sv -----
// Word store of the bitmap: one read port, one write port, valid bits for reset.
module bpc_store (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             rd_en_i,
  input  bpc_pkg::addr_t   rd_addr_i,
  output bpc_pkg::word_t   rd_data_o,
  input  bpc_pkg::wr_req_t wr_i
);

  bpc_pkg::word_t                      mem_q [bpc_pkg::STORE_WORDS];
  logic [bpc_pkg::STORE_WORDS-1:0]     valid_q;
  bpc_pkg::word_t                      rd_word_q;
  logic                                rd_valid_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    if (rd_en_i) begin
      rd_word_q <= mem_q[rd_addr_i];
    end
  end

  // Entry never written since reset reads as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (wr_i.en) begin
        valid_q[wr_i.addr] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_valid_q <= valid_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_valid_q ? rd_word_q : '0;

endmodule

// ----- hw/rtl/bitmap_with_population_count_core.sv -----
// Top level of the bitmap with population count.
//
// A bitmap of bpc_pkg::CAPACITY_BITS bits held in a synchronous word store
// (bpc_pkg::WORD_BITS bits a word), plus a counter of set bits. Each input
// beat reads a bit, writes a bit, or clears the whole map, and produces
// exactly one output beat carrying the addressed bit, the set and unset
// counts and an index error flag. A read or write first reads the word
// from the store, then updates it, writes it back and loads the output
// register, waiting while an earlier result is still held. A clear-all
// walks every word of the store (128 words in the default build), zeroing
// each in turn. The store needs no clearing pass after
// reset: per-word valid bits make unwritten words read as zero. in_ready_o
// is high whenever the block is idle, even while an earlier result waits
// in the output register; a new item then stalls only when its own result
// is ready before the old one is taken. An index at or beyond capacity
// returns bit 0 with index_error_o set, and a write to it changes nothing.
// Operation code 3 acts as a read.
module bitmap_with_population_count_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [1:0]                  func_i,
  input  logic [bpc_pkg::IDX_W-1:0]   bit_index_i,
  input  logic                        bit_value_in_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        bit_value_o,
  output logic [bpc_pkg::COUNT_W-1:0] set_count_o,
  output logic [bpc_pkg::COUNT_W-1:0] unset_count_o,
  output logic                        index_error_o
);

  bpc_pkg::state_e state_q, state_d;

  // Request registers, loaded on input beat.
  logic [1:0]                  func_q;
  logic [bpc_pkg::IDX_W-1:0]   idx_q;
  logic                        val_q;

  logic [bpc_pkg::CNT_W-1:0]   ones_q, ones_d;
  bpc_pkg::addr_t              ptr_q, ptr_d;

  // Output register.
  logic                        out_valid_q;
  logic                        out_bit_q, out_bit_d;
  logic [bpc_pkg::COUNT_W-1:0] out_set_q, out_set_d;
  logic [bpc_pkg::COUNT_W-1:0] out_unset_q, out_unset_d;
  logic                        out_err_q, out_err_d;

  logic             in_fire;
  logic             out_free;
  logic             load_out;
  logic             rd_en;
  bpc_pkg::wr_req_t wr;
  bpc_pkg::word_t   rd_word;
  bpc_pkg::word_t   new_word;
  logic             idx_err;
  logic             was_set;
  logic             is_write;
  logic             changes;
  logic             wipe_last;
  logic [bpc_pkg::SEL_W-1:0] sel;
  bpc_pkg::addr_t   word_addr;

  bpc_store u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (rd_en),
    .rd_addr_i (word_addr),
    .rd_data_o (rd_word),
    .wr_i      (wr)
  );

  assign in_ready_o = (state_q == bpc_pkg::ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  // Address comes straight from the port on the accepting beat so the
  // store read lines up with the next cycle.
  assign word_addr = in_fire ? bit_index_i[bpc_pkg::SEL_W +: bpc_pkg::ADDR_W]
                             : idx_q[bpc_pkg::SEL_W +: bpc_pkg::ADDR_W];
  assign sel       = idx_q[bpc_pkg::SEL_W-1:0];
  assign idx_err   = {1'b0, idx_q} >= bpc_pkg::IDX_LIMIT;
  assign was_set   = rd_word[sel];
  assign is_write  = (func_q == bpc_pkg::FUNC_WRITE);
  assign changes   = is_write && !idx_err && (was_set != val_q);
  assign wipe_last = (ptr_q == bpc_pkg::LAST_WORD);

  always_comb begin
    new_word      = rd_word;
    new_word[sel] = val_q;
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bpc_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_d = (func_i == bpc_pkg::FUNC_CLEAR) ? bpc_pkg::ST_WIPE
                                                     : bpc_pkg::ST_RMW;
        end
      end
      bpc_pkg::ST_RMW: begin
        if (out_free) begin
          state_d = bpc_pkg::ST_IDLE;
        end
      end
      bpc_pkg::ST_WIPE: begin
        if (wipe_last && out_free) begin
          state_d = bpc_pkg::ST_IDLE;
        end
      end
      default: state_d = bpc_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the sequencer: store port, counter, pointer, result.
  always_comb begin
    rd_en       = 1'b0;
    wr          = '0;
    load_out    = 1'b0;
    ones_d      = ones_q;
    ptr_d       = ptr_q;
    out_bit_d   = out_bit_q;
    out_set_d   = out_set_q;
    out_unset_d = out_unset_q;
    out_err_d   = out_err_q;
    unique case (state_q)
      bpc_pkg::ST_IDLE: begin
        rd_en = in_fire && (func_i != bpc_pkg::FUNC_CLEAR);
        if (in_fire) begin
          ptr_d = '0;
        end
      end
      bpc_pkg::ST_RMW: begin
        if (out_free) begin
          load_out = 1'b1;
          wr.en    = changes;
          wr.addr  = idx_q[bpc_pkg::SEL_W +: bpc_pkg::ADDR_W];
          wr.data  = new_word;
          if (changes) begin
            ones_d = val_q ? ones_q + 1'b1 : ones_q - 1'b1;
          end
          out_bit_d   = !idx_err && (is_write ? val_q : was_set);
          out_set_d   = bpc_pkg::COUNT_W'(ones_d);
          out_unset_d = bpc_pkg::COUNT_W'(bpc_pkg::CNT_CAP - ones_d);
          out_err_d   = idx_err;
        end
      end
      bpc_pkg::ST_WIPE: begin
        // Zero one word a cycle; hold on the last word until the
        // output register frees up.
        wr.en   = 1'b1;
        wr.addr = ptr_q;
        wr.data = '0;
        if (!wipe_last) begin
          ptr_d = ptr_q + 1'b1;
        end else if (out_free) begin
          load_out    = 1'b1;
          ptr_d       = '0;
          ones_d      = '0;
          out_bit_d   = 1'b0;
          out_set_d   = '0;
          out_unset_d = bpc_pkg::COUNT_W'(bpc_pkg::CNT_CAP);
          out_err_d   = 1'b0;
        end
      end
      default: begin
        ptr_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bpc_pkg::ST_IDLE;
      ones_q      <= '0;
      ptr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ones_q  <= ones_d;
      ptr_q   <= ptr_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      func_q <= func_i;
      idx_q  <= bit_index_i;
      val_q  <= bit_value_in_i;
    end
    out_bit_q   <= out_bit_d;
    out_set_q   <= out_set_d;
    out_unset_q <= out_unset_d;
    out_err_q   <= out_err_d;
  end

  assign out_valid_o   = out_valid_q;
  assign bit_value_o   = out_bit_q;
  assign set_count_o   = out_set_q;
  assign unset_count_o = out_unset_q;
  assign index_error_o = out_err_q;

endmodule

// ----- hw/rtl/bpc_checker.sv -----
// Port-level checks for the bitmap with population count, bound to the top level.
`include "assert_macros.svh"

module bpc_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_o,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic                        bit_value_o,
  input logic [bpc_pkg::COUNT_W-1:0] set_count_o,
  input logic [bpc_pkg::COUNT_W-1:0] unset_count_o,
  input logic                        index_error_o
);

  logic [bpc_pkg::COUNT_W:0] count_sum;
  assign count_sum = {1'b0, set_count_o} + {1'b0, unset_count_o};

  `BPC_ASSERT(a_count_sum, out_valid_o |-> (count_sum[bpc_pkg::COUNT_W-1:0] == bpc_pkg::COUNT_W'(bpc_pkg::CAPACITY_BITS)), "set and unset counts do not add up to capacity")
  `BPC_ASSERT(a_err_bit_zero, (out_valid_o && index_error_o) |-> !bit_value_o, "out-of-range beat returned a set bit")
  `BPC_ASSERT(a_busy_after_accept, (in_valid_i && in_ready_o) |=> !in_ready_o, "ready stayed high right after an input beat")
  `BPC_ASSERT(a_out_hold, (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(set_count_o)), "stalled output beat dropped or changed")

endmodule

bind bitmap_with_population_count_core bpc_checker u_bpc_checker (.*);
